[rtl/cau_pkg.sv]
`default_nettype none

package cau_pkg;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_CONJ = 3'd4,
		OP_MAG = 3'd5
	} op_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	typedef struct packed {
		logic is_div;
		logic divz;
		logic neg_re;
		logic neg_im;
		logic ovf_re;
		logic ovf_im;
		logic sat;
	} flags_t;

endpackage

`default_nettype wire

[rtl/complex_arithmetic_unit.sv]
// Complex arithmetic unit on signed fixed-point operands (Q3.12 by default): add, subtract,
// multiply, divide, conjugate and squared magnitude, with rounding to nearest, saturation
// and a status code per result. The pipeline takes one item every cycle, and most of its
// depth is the restoring divider, which resolves one quotient bit per stage. The whole
// pipeline holds while a result waits to be taken.
`default_nettype none

module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [2:0] op,
	input wire logic signed [DATA_WIDTH-1:0] a_re,
	input wire logic signed [DATA_WIDTH-1:0] a_im,
	input wire logic signed [DATA_WIDTH-1:0] b_re,
	input wire logic signed [DATA_WIDTH-1:0] b_im,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic [1:0] status
);

	localparam int DW = DATA_WIDTH;
	localparam int PW = 2 * DW;
	localparam int MW = PW + 1;
	localparam int NW = PW + FRAC_BITS;
	localparam int QW = DW + 1;
	localparam int CW = NW + QW + 2;
	localparam int FW = $bits(cau_pkg::flags_t);
	localparam int SBW = FW + 2 * DW;
	localparam logic [CW-1:0] HALF = (FRAC_BITS > 0) ? (CW'(1) << (FRAC_BITS - 1)) : '0;
	localparam logic [CW-1:0] LIM = CW'(1) << (DW - 1);

	function automatic logic [DW:0] fin(input logic neg, input logic [CW-1:0] mag);
		logic [CW-1:0] m;
		logic s;
		begin
			m = mag;
			s = 1'b0;
			if (neg) begin
				if (mag > LIM) begin
					m = LIM;
					s = 1'b1;
				end
				m = CW'(0) - m;
			end else if (mag > LIM - CW'(1)) begin
				m = LIM - CW'(1);
				s = 1'b1;
			end
			fin = {s, m[DW-1:0]};
		end
	endfunction

	logic en;
	logic out_valid_q;
	logic [DW-1:0] res_re_q;
	logic [DW-1:0] res_im_q;
	logic [1:0] status_q;

	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	logic is_mag;
	assign is_mag = (op == cau_pkg::OP_MAG);

	logic v_s1;
	logic [2:0] op_s1;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_bb_s1, p_cc_s1;
	logic signed [DW:0] sum_re_s1, sum_im_s1, conj_im_s1;
	logic signed [DW-1:0] a_re_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op;
			p_rr_s1 <= a_re * (is_mag ? a_re : b_re);
			p_ii_s1 <= a_im * (is_mag ? a_im : b_im);
			p_ri_s1 <= a_re * b_im;
			p_ir_s1 <= a_im * b_re;
			p_bb_s1 <= b_re * b_re;
			p_cc_s1 <= b_im * b_im;
			if (op == cau_pkg::OP_SUB) begin
				sum_re_s1 <= (DW+1)'(a_re) - (DW+1)'(b_re);
				sum_im_s1 <= (DW+1)'(a_im) - (DW+1)'(b_im);
			end else begin
				sum_re_s1 <= (DW+1)'(a_re) + (DW+1)'(b_re);
				sum_im_s1 <= (DW+1)'(a_im) + (DW+1)'(b_im);
			end
			conj_im_s1 <= -((DW+1)'(a_im));
			a_re_s1 <= a_re;
		end
	end

	logic v_s2;
	logic [2:0] op_s2;
	logic signed [MW-1:0] acc_re_s2, acc_im_s2;
	logic [PW-1:0] den_s2;
	logic [DW-1:0] pre_re_s2, pre_im_s2;
	logic pre_sat_s2;

	logic [DW:0] f_re1, f_im1, f_cj;
	logic [DW-1:0] pre_re1, pre_im1;
	logic pre_sat1;
	assign f_re1 = fin(sum_re_s1 < 0, CW'(sum_re_s1 < 0 ? -sum_re_s1 : sum_re_s1));
	assign f_im1 = fin(sum_im_s1 < 0, CW'(sum_im_s1 < 0 ? -sum_im_s1 : sum_im_s1));
	assign f_cj = fin(conj_im_s1 < 0, CW'(conj_im_s1 < 0 ? -conj_im_s1 : conj_im_s1));

	always_comb begin
		case (op_s1)
			cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
				pre_re1 = f_re1[DW-1:0];
				pre_im1 = f_im1[DW-1:0];
				pre_sat1 = f_re1[DW] | f_im1[DW];
			end
			cau_pkg::OP_CONJ: begin
				pre_re1 = a_re_s1;
				pre_im1 = f_cj[DW-1:0];
				pre_sat1 = f_cj[DW];
			end
			default: begin
				pre_re1 = '0;
				pre_im1 = '0;
				pre_sat1 = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2 <= op_s1;
			den_s2 <= PW'(p_bb_s1) + PW'(p_cc_s1);
			pre_re_s2 <= pre_re1;
			pre_im_s2 <= pre_im1;
			pre_sat_s2 <= pre_sat1;
			if (op_s1 == cau_pkg::OP_MUL) begin
				acc_re_s2 <= MW'(p_rr_s1) - MW'(p_ii_s1);
			end else begin
				acc_re_s2 <= MW'(p_rr_s1) + MW'(p_ii_s1);
			end
			if (op_s1 == cau_pkg::OP_DIV) begin
				acc_im_s2 <= MW'(p_ir_s1) - MW'(p_ri_s1);
			end else begin
				acc_im_s2 <= MW'(p_ri_s1) + MW'(p_ir_s1);
			end
		end
	end

	logic v_s3;
	logic [NW-1:0] num_re_s3, num_im_s3;
	logic [PW-1:0] den_s3;
	logic [SBW-1:0] side_s3;

	logic neg_re2, neg_im2;
	logic [CW-1:0] mag_re2, mag_im2, nre2, nim2, lim_div2;
	logic [DW:0] f_rm, f_im_m;
	cau_pkg::flags_t fl2;
	logic [SBW-1:0] side2;

	always_comb begin
		neg_re2 = acc_re_s2 < 0;
		neg_im2 = acc_im_s2 < 0;
		mag_re2 = CW'(neg_re2 ? -acc_re_s2 : acc_re_s2);
		mag_im2 = CW'(neg_im2 ? -acc_im_s2 : acc_im_s2);
		nre2 = mag_re2 << FRAC_BITS;
		nim2 = mag_im2 << FRAC_BITS;
		lim_div2 = CW'(den_s2) << QW;
		f_rm = fin(neg_re2, (mag_re2 + HALF) >> FRAC_BITS);
		f_im_m = fin(neg_im2, (mag_im2 + HALF) >> FRAC_BITS);
		fl2.is_div = (op_s2 == cau_pkg::OP_DIV);
		fl2.divz = (op_s2 == cau_pkg::OP_DIV) && (den_s2 == '0);
		fl2.neg_re = neg_re2;
		fl2.neg_im = neg_im2;
		fl2.ovf_re = nre2 >= lim_div2;
		fl2.ovf_im = nim2 >= lim_div2;
		case (op_s2)
			cau_pkg::OP_MUL: begin
				fl2.sat = f_rm[DW] | f_im_m[DW];
				side2 = {fl2, f_rm[DW-1:0], f_im_m[DW-1:0]};
			end
			cau_pkg::OP_MAG: begin
				fl2.sat = f_rm[DW];
				side2 = {fl2, f_rm[DW-1:0], {DW{1'b0}}};
			end
			default: begin
				fl2.sat = pre_sat_s2;
				side2 = {fl2, pre_re_s2, pre_im_s2};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_re_s3 <= fl2.ovf_re ? '0 : NW'(nre2);
			num_im_s3 <= fl2.ovf_im ? '0 : NW'(nim2);
			den_s3 <= den_s2;
			side_s3 <= side2;
		end
	end

	logic dv;
	logic [QW-1:0] dq_re, dq_im;
	logic [NW-1:0] dr_re, dr_im;
	logic [PW-1:0] dden;
	logic [SBW-1:0] dside;

	cau_div #(
		.NW(NW),
		.DW(PW),
		.QW(QW),
		.CW(CW),
		.SBW(SBW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s3),
		.num_re(num_re_s3),
		.num_im(num_im_s3),
		.den(den_s3),
		.side(side_s3),
		.out_valid(dv),
		.q_re(dq_re),
		.q_im(dq_im),
		.rem_re(dr_re),
		.rem_im(dr_im),
		.den_out(dden),
		.side_out(dside)
	);

	cau_pkg::flags_t flo;
	logic [CW-1:0] qr_re, qr_im;
	logic [DW:0] fq_re, fq_im;
	logic [DW-1:0] o_re, o_im;
	logic o_sat;

	always_comb begin
		flo = dside[SBW-1:SBW-FW];
		qr_re = CW'(dq_re) + CW'(({dr_re, 1'b0} >= (NW+1)'(dden)) ? 1'b1 : 1'b0);
		qr_im = CW'(dq_im) + CW'(({dr_im, 1'b0} >= (NW+1)'(dden)) ? 1'b1 : 1'b0);
		fq_re = fin(flo.neg_re, flo.ovf_re ? LIM + CW'(1) : qr_re);
		fq_im = fin(flo.neg_im, flo.ovf_im ? LIM + CW'(1) : qr_im);
		if (flo.is_div) begin
			o_re = fq_re[DW-1:0];
			o_im = fq_im[DW-1:0];
			o_sat = fq_re[DW] | fq_im[DW];
		end else begin
			o_re = dside[2*DW-1:DW];
			o_im = dside[DW-1:0];
			o_sat = flo.sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (flo.divz) begin
				res_re_q <= '0;
				res_im_q <= '0;
				status_q <= cau_pkg::ST_DIVZ;
			end else begin
				res_re_q <= o_re;
				res_im_q <= o_im;
				status_q <= o_sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res_re = res_re_q;
	assign res_im = res_im_q;
	assign status = status_q;

endmodule

`default_nettype wire

[rtl/cau_div.sv]
`default_nettype none

module cau_div #(
	parameter int NW = 44,
	parameter int DW = 32,
	parameter int QW = 17,
	parameter int CW = 62,
	parameter int SBW = 39
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire logic [NW-1:0] num_re,
	input wire logic [NW-1:0] num_im,
	input wire logic [DW-1:0] den,
	input wire logic [SBW-1:0] side,
	output logic out_valid,
	output logic [QW-1:0] q_re,
	output logic [QW-1:0] q_im,
	output logic [NW-1:0] rem_re,
	output logic [NW-1:0] rem_im,
	output logic [DW-1:0] den_out,
	output logic [SBW-1:0] side_out
);

	logic v_s [QW];
	logic [NW-1:0] nre_s [QW];
	logic [NW-1:0] nim_s [QW];
	logic [QW-1:0] qre_s [QW];
	logic [QW-1:0] qim_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [SBW-1:0] side_s [QW];

	logic [NW-1:0] cre [QW];
	logic [NW-1:0] cim [QW];
	logic [QW-1:0] cqre [QW];
	logic [QW-1:0] cqim [QW];
	logic [DW-1:0] cden [QW];
	logic [SBW-1:0] cside [QW];
	logic cv [QW];

	logic [NW-1:0] nxre [QW];
	logic [NW-1:0] nxim [QW];
	logic [QW-1:0] nqre [QW];
	logic [QW-1:0] nqim [QW];

	always_comb begin
		cre[0] = num_re;
		cim[0] = num_im;
		cqre[0] = '0;
		cqim[0] = '0;
		cden[0] = den;
		cside[0] = side;
		cv[0] = in_valid;
		for (int k = 1; k < QW; k++) begin
			cre[k] = nre_s[k-1];
			cim[k] = nim_s[k-1];
			cqre[k] = qre_s[k-1];
			cqim[k] = qim_s[k-1];
			cden[k] = den_s[k-1];
			cside[k] = side_s[k-1];
			cv[k] = v_s[k-1];
		end
	end

	always_comb begin
		logic [CW-1:0] trial;
		logic [CW-1:0] xre;
		logic [CW-1:0] xim;
		for (int k = 0; k < QW; k++) begin
			trial = CW'(cden[k]) << (QW - 1 - k);
			xre = CW'(cre[k]);
			xim = CW'(cim[k]);
			if (xre >= trial) begin
				nxre[k] = NW'(xre - trial);
				nqre[k] = {cqre[k][QW-2:0], 1'b1};
			end else begin
				nxre[k] = cre[k];
				nqre[k] = {cqre[k][QW-2:0], 1'b0};
			end
			if (xim >= trial) begin
				nxim[k] = NW'(xim - trial);
				nqim[k] = {cqim[k][QW-2:0], 1'b1};
			end else begin
				nxim[k] = cim[k];
				nqim[k] = {cqim[k][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (en) begin
			for (int k = 0; k < QW; k++) begin
				v_s[k] <= cv[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				nre_s[k] <= nxre[k];
				nim_s[k] <= nxim[k];
				qre_s[k] <= nqre[k];
				qim_s[k] <= nqim[k];
				den_s[k] <= cden[k];
				side_s[k] <= cside[k];
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign q_re = qre_s[QW-1];
	assign q_im = qim_s[QW-1];
	assign rem_re = nre_s[QW-1];
	assign rem_im = nim_s[QW-1];
	assign den_out = den_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

`default_nettype wire

[verif/complex_arithmetic_unit_tb.sv]
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;

	localparam int DW = 16;
	localparam int FB = 12;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
		logic [1:0] st;
	} cresult_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] op = '0;
	logic signed [DW-1:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DW-1:0] res_re, res_im;
	logic [1:0] status;

	cresult_t expected_q[$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0;

	complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.out_valid(out_valid), .out_ready(out_ready),
		.res_re(res_re), .res_im(res_im), .status(status)
	);

	always #5 clk = ~clk;

	function automatic logic [127:0] round_mag(logic [127:0] m);
		return (m + (128'd1 << (FB - 1))) >> FB;
	endfunction

	function automatic logic signed [DW-1:0] saturate(logic neg, logic [127:0] m, ref logic sat);
		logic [127:0] lim;
		lim = 128'd1 << (DW - 1);
		if (neg) begin
			if (m > lim) begin
				m = lim;
				sat = 1'b1;
			end
			return DW'(-m);
		end
		if (m > lim - 1) begin
			m = lim - 1;
			sat = 1'b1;
		end
		return DW'(m);
	endfunction

	// Rounded quotient num * 2^FB / den, to nearest with ties away from zero.
	function automatic logic [127:0] rounded_quot(logic [127:0] num, logic [127:0] den);
		logic [127:0] q, r;
		q = (num << FB) / den;
		r = (num << FB) % den;
		if (q >= (128'd1 << 40))
			return 128'd1 << 40;
		if (r >= den - r)
			q = q + 1;
		return q;
	endfunction

	function automatic logic [127:0] mag_of(longint v);
		return v < 0 ? 128'(-v) : 128'(v);
	endfunction

	function automatic cresult_t predict_cplx(logic [2:0] o, logic signed [DW-1:0] ar,
			logic signed [DW-1:0] ai, logic signed [DW-1:0] br, logic signed [DW-1:0] bi);
		cresult_t r;
		logic sat;
		longint x, y, den;
		r.re = '0;
		r.im = '0;
		r.st = cau_pkg::ST_OK;
		sat = 1'b0;
		case (o)
			cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
				x = (o == cau_pkg::OP_ADD) ? longint'(ar) + br : longint'(ar) - br;
				y = (o == cau_pkg::OP_ADD) ? longint'(ai) + bi : longint'(ai) - bi;
				r.re = saturate(x < 0, mag_of(x), sat);
				r.im = saturate(y < 0, mag_of(y), sat);
			end
			cau_pkg::OP_MUL: begin
				x = longint'(ar) * br - longint'(ai) * bi;
				y = longint'(ar) * bi + longint'(ai) * br;
				r.re = saturate(x < 0, round_mag(mag_of(x)), sat);
				r.im = saturate(y < 0, round_mag(mag_of(y)), sat);
			end
			cau_pkg::OP_DIV: begin
				den = longint'(br) * br + longint'(bi) * bi;
				if (den == 0) begin
					r.st = cau_pkg::ST_DIVZ;
				end else begin
					x = longint'(ar) * br + longint'(ai) * bi;
					y = longint'(ai) * br - longint'(ar) * bi;
					r.re = saturate(x < 0, rounded_quot(mag_of(x), 128'(den)), sat);
					r.im = saturate(y < 0, rounded_quot(mag_of(y), 128'(den)), sat);
				end
			end
			cau_pkg::OP_CONJ: begin
				r.re = ar;
				r.im = saturate(ai > 0, mag_of(longint'(ai)), sat);
			end
			cau_pkg::OP_MAG: begin
				x = longint'(ar) * ar + longint'(ai) * ai;
				r.re = saturate(1'b0, round_mag(128'(x)), sat);
			end
			default: ;
		endcase
		if (r.st == cau_pkg::ST_OK && sat)
			r.st = cau_pkg::ST_SAT;
		return r;
	endfunction

	task automatic send_item(logic [2:0] o, logic signed [DW-1:0] ar, logic signed [DW-1:0] ai,
			logic signed [DW-1:0] br, logic signed [DW-1:0] bi);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		op <= o;
		a_re <= ar;
		a_im <= ai;
		b_re <= br;
		b_im <= bi;
		expected_q.push_back(predict_cplx(o, ar, ai, br, bi));
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	function automatic logic signed [DW-1:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return '0;
			3: return DW'($urandom_range(0, 16'h3fff)) - 16'sh2000;
			default: return DW'($urandom());
		endcase
	endfunction

	task automatic test_directed();
		logic signed [DW-1:0] mx, mn;
		mx = 16'sh7fff;
		mn = 16'sh8000;
		send_item(cau_pkg::OP_ADD, mx, mn, mx, mn);
		send_item(cau_pkg::OP_ADD, 16'sh1000, 16'sh2000, 16'sh0800, -16'sh0400);
		send_item(cau_pkg::OP_SUB, mn, mx, mx, mn);
		send_item(cau_pkg::OP_SUB, 16'sh1234, -16'sh0111, 16'sh0234, 16'sh0fff);
		send_item(cau_pkg::OP_MUL, mx, mx, mx, mx);
		send_item(cau_pkg::OP_MUL, mn, mn, mn, mn);
		send_item(cau_pkg::OP_MUL, 16'sh1000, 16'sh0800, -16'sh1000, 16'sh0001);
		send_item(cau_pkg::OP_MUL, 16'sh0001, 16'sh0001, 16'sh0800, -16'sh0800);
		send_item(cau_pkg::OP_DIV, 16'sh1000, 16'sh1000, 16'sh0000, 16'sh0000);
		send_item(cau_pkg::OP_DIV, mx, mx, 16'sh0000, 16'sh0000);
		send_item(cau_pkg::OP_DIV, mx, mn, 16'sh0001, 16'sh0000);
		send_item(cau_pkg::OP_DIV, 16'sh1000, 16'sh0000, 16'sh2000, 16'sh1000);
		send_item(cau_pkg::OP_DIV, mn, mn, mn, mn);
		send_item(cau_pkg::OP_CONJ, mn, mn, mx, mx);
		send_item(cau_pkg::OP_CONJ, mx, mx, 16'sh0000, 16'sh0000);
		send_item(cau_pkg::OP_CONJ, 16'sh1234, 16'sh0000, mn, mn);
		send_item(cau_pkg::OP_MAG, mx, mx, mn, mn);
		send_item(cau_pkg::OP_MAG, 16'sh1000, -16'sh1000, 16'sh0000, 16'sh0000);
		send_item(cau_pkg::OP_MAG, 16'sh0000, 16'sh0000, mx, mx);
		send_item(3'd6, mx, mn, mx, mn);
		send_item(3'd7, mn, mx, mn, mx);
	endtask

	task automatic test_random();
		logic [2:0] o;
		repeat (400) begin
			o = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
			if (o == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0)
				send_item(o, rand_val(), rand_val(), '0, '0);
			else
				send_item(o, rand_val(), rand_val(), rand_val(), rand_val());
		end
	endtask

	always @(negedge clk) begin
		case (cycles % 64 / 16)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		cresult_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (res_re !== e.re) begin
					$error("res_re expected %0d actual %0d", e.re, res_re);
					errors++;
				end
				if (res_im !== e.im) begin
					$error("res_im expected %0d actual %0d", e.im, res_im);
					errors++;
				end
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random();
		in_valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (4 * (DW + 5)) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
